@@ rtl/core/gbda_pkg.sv @@
// Shared types and constants of the group-by-dimensions average block.
// Item structs, function codes and register indexes; no dependencies.

package gbda_pkg;

  // Default sizes of the top level
  localparam int MAX_DIMS_DEF    = 4;
  localparam int BIN_DEPTH_DEF   = 1024;
  localparam int EXTENT_BITS_DEF = 10;

  // Fixed field widths
  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int BIN_IDX_W  = 10;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 32;
  localparam int FRAC_BITS  = 16;
  localparam int AVG_W      = SUM_W + FRAC_BITS;
  localparam int NUM_DIMS_W = 3;
  localparam int EXT_REG_W  = 11;
  localparam int MASK_W     = 4;
  localparam int NUM_EXT_REGS = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_DIM0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_DIM1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_DIM2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_DIM3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MASK = 3'd5;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_ACCUM   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] cell_value;
    logic [BIN_IDX_W-1:0]      bin_index;
  } in_item_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    bin_empty;
    logic [CNT_W-1:0]        bin_count;
  } out_item_t;

endpackage

@@ rtl/core/group_by_dims_average.sv @@
// Group-by-dimensions average: top level with sequencer, bin store and index unit.
// Depends on gbda_pkg and gbda_div.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o   | gbda_pkg::in_item_t
//  out     | output    | out_valid_o/out_stall_i | gbda_pkg::out_item_t
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Accumulate runs two passes of the shared multiplier per dimension, then a
// read-modify-write of the bin store.
// Read runs the bit-serial divider; an empty bin skips it and goes straight to the output.
// Reset and restart run a clearing pass over every bin with in_stall_o high.
// A result waiting on out_stall_i does not hold back accumulate items; a further read
// waits until the output register frees. BIN_DEPTH must be a power of two.

module group_by_dims_average #(
  parameter int MAX_DIMS    = gbda_pkg::MAX_DIMS_DEF,
  parameter int BIN_DEPTH   = gbda_pkg::BIN_DEPTH_DEF,
  parameter int EXTENT_BITS = gbda_pkg::EXTENT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gbda_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gbda_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbda_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gbda_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int BinBits = $clog2(BIN_DEPTH);
  localparam int DimW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ExtEffW = EXTENT_BITS + 1;
  localparam int ExtCmpW = (ExtEffW > gbda_pkg::EXT_REG_W) ? ExtEffW : gbda_pkg::EXT_REG_W;
  localparam int ProdW   = BinBits + ExtEffW;
  localparam int WordW   = gbda_pkg::SUM_W + gbda_pkg::CNT_W;
  localparam int NdW     = 4;
  localparam logic [ExtCmpW-1:0] ExtCap = ExtCmpW'(1) << EXTENT_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_ADV, S_ACC_RD, S_ACC_WR, S_RD_RD, S_RD_CHK, S_DIV, S_OUT
  } state_e;

  // Extent register value as used: zero acts as one, large values saturate
  function automatic logic [ExtEffW-1:0] eff_extent(input logic [gbda_pkg::EXT_REG_W-1:0] raw);
    logic [ExtCmpW-1:0] w;
    w = ExtCmpW'(raw);
    if (w == '0) begin
      w = ExtCmpW'(1);
    end else if (w > ExtCap) begin
      w = ExtCap;
    end
    return ExtEffW'(w);
  endfunction

  // Configuration registers
  logic [gbda_pkg::NUM_DIMS_W-1:0] num_dims_q;
  logic [gbda_pkg::EXT_REG_W-1:0]  ext_q [gbda_pkg::NUM_EXT_REGS];
  logic [gbda_pkg::MASK_W-1:0]     mask_q;

  // Sequencer state
  state_e                    state_q;
  logic [BinBits-1:0]        clr_q;
  logic [EXTENT_BITS-1:0]    coord_q [MAX_DIMS];
  logic [DimW-1:0]           dim_q;
  logic                      carry_q;
  logic [BinBits-1:0]        idx_q;
  logic [BinBits-1:0]        stride_q;
  logic [BinBits-1:0]        mul_q;
  logic [gbda_pkg::SUM_W-1:0] cell_q;
  logic                      neg_q;
  gbda_pkg::out_item_t       res_q;
  logic                      out_valid_q;
  gbda_pkg::out_item_t       out_data_q;

  // Bin store: {sum, count} per bin
  logic [WordW-1:0]   mem [BIN_DEPTH];
  logic [WordW-1:0]   mem_rdata_q;
  logic               mem_we;
  logic [BinBits-1:0] mem_addr;
  logic [WordW-1:0]   mem_wdata;

  // Per-dimension extent and selection
  logic [ExtEffW-1:0]  dim_ext [MAX_DIMS];
  logic [MAX_DIMS-1:0] dim_sel;

  logic [NdW-1:0]     nd_raw;
  logic [NdW-1:0]     nd_eff;
  logic [BinBits-1:0] mul_a;
  logic [ExtEffW-1:0] mul_b;
  logic [ProdW-1:0]   mul_prod;
  logic [ExtEffW-1:0] coord_next;
  logic               coord_wrap;
  logic [gbda_pkg::SUM_W-1:0] rd_sum;
  logic [gbda_pkg::CNT_W-1:0] rd_cnt;
  logic [gbda_pkg::SUM_W-1:0] rd_mag;
  logic               div_start;
  logic               div_done;
  logic [gbda_pkg::AVG_W-1:0] div_quot;
  logic               in_accept;
  logic               out_free;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    if (k < gbda_pkg::NUM_EXT_REGS) begin : g_reg
      assign dim_ext[k] = eff_extent(ext_q[k]);
      assign dim_sel[k] = mask_q[k];
    end else begin : g_fixed
      assign dim_ext[k] = ExtEffW'(1);
      assign dim_sel[k] = 1'b0;
    end
  end

  // Dimensions in use, clamped to 1..MAX_DIMS
  always_comb begin
    nd_raw = NdW'(num_dims_q);
    if (nd_raw == '0) begin
      nd_eff = NdW'(1);
    end else if (nd_raw > NdW'(MAX_DIMS)) begin
      nd_eff = NdW'(MAX_DIMS);
    end else begin
      nd_eff = nd_raw;
    end
  end

  // Shared multiplier: coord*stride in S_MUL, stride*extent in S_ADV
  always_comb begin
    mul_a    = stride_q;
    mul_b    = (state_q == S_MUL) ? ExtEffW'(coord_q[dim_q]) : dim_ext[dim_q];
    mul_prod = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // Coordinate increment and carry test for the current dimension
  always_comb begin
    coord_next = ExtEffW'(coord_q[dim_q]) + ExtEffW'(1);
    coord_wrap = (coord_next >= dim_ext[dim_q]);
  end

  // Bin word fields
  always_comb begin
    rd_sum = mem_rdata_q[WordW-1 -: gbda_pkg::SUM_W];
    rd_cnt = mem_rdata_q[gbda_pkg::CNT_W-1:0];
    rd_mag = rd_sum[gbda_pkg::SUM_W-1] ? (~rd_sum + gbda_pkg::SUM_W'(1)) : rd_sum;
  end

  // Store port control
  always_comb begin
    mem_we    = (state_q == S_CLEAR) || (state_q == S_ACC_WR);
    mem_addr  = (state_q == S_CLEAR) ? clr_q : idx_q;
    mem_wdata = '0;
    if (state_q == S_ACC_WR) begin
      mem_wdata[WordW-1 -: gbda_pkg::SUM_W] = rd_sum + cell_q;
      mem_wdata[gbda_pkg::CNT_W-1:0] = (rd_cnt == '1) ? rd_cnt : rd_cnt + gbda_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  assign div_start = (state_q == S_RD_CHK) && (rd_cnt != '0);

  gbda_div #(
    .DIVIDEND_W (gbda_pkg::AVG_W),
    .DIVISOR_W  (gbda_pkg::CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({rd_mag, gbda_pkg::FRAC_BITS'(0)}),
    .divisor_i  (rd_cnt),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= gbda_pkg::NUM_DIMS_W'(1);
      for (int i = 0; i < gbda_pkg::NUM_EXT_REGS; i++) begin
        ext_q[i] <= gbda_pkg::EXT_REG_W'(1);
      end
      mask_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbda_pkg::CFG_NUM_DIMS:    num_dims_q <= cfg_data_i[gbda_pkg::NUM_DIMS_W-1:0];
        gbda_pkg::CFG_EXTENT_DIM0: ext_q[0] <= cfg_data_i;
        gbda_pkg::CFG_EXTENT_DIM1: ext_q[1] <= cfg_data_i;
        gbda_pkg::CFG_EXTENT_DIM2: ext_q[2] <= cfg_data_i;
        gbda_pkg::CFG_EXTENT_DIM3: ext_q[3] <= cfg_data_i;
        gbda_pkg::CFG_SELECT_MASK: mask_q <= cfg_data_i[gbda_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        coord_q[i] <= '0;
      end
      dim_q       <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // output register drains independently; S_OUT reloads it itself
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + BinBits'(1);
          if (clr_q == BinBits'(BIN_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_accept) begin
            case (in_data_i.func)
              gbda_pkg::FUNC_ACCUM: begin
                cell_q   <= in_data_i.cell_value;
                dim_q    <= DimW'(nd_eff - NdW'(1));
                carry_q  <= 1'b1;
                idx_q    <= '0;
                stride_q <= BinBits'(1);
                state_q  <= S_MUL;
              end
              gbda_pkg::FUNC_READ: begin
                idx_q   <= BinBits'(in_data_i.bin_index);
                state_q <= S_RD_RD;
              end
              gbda_pkg::FUNC_RESTART: begin
                for (int i = 0; i < MAX_DIMS; i++) begin
                  coord_q[i] <= '0;
                end
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end

        // coordinate times stride, using the old coordinate
        S_MUL: begin
          mul_q   <= mul_prod[BinBits-1:0];
          state_q <= S_ADV;
        end

        // fold into bin index, grow stride, step the coordinate counter
        S_ADV: begin
          if (dim_sel[dim_q]) begin
            idx_q    <= idx_q + mul_q;
            stride_q <= mul_prod[BinBits-1:0];
          end
          if (carry_q) begin
            if (coord_wrap) begin
              coord_q[dim_q] <= '0;
            end else begin
              coord_q[dim_q] <= coord_next[EXTENT_BITS-1:0];
              carry_q        <= 1'b0;
            end
          end
          if (dim_q == '0) begin
            state_q <= S_ACC_RD;
          end else begin
            dim_q   <= dim_q - DimW'(1);
            state_q <= S_MUL;
          end
        end

        S_ACC_RD: state_q <= S_ACC_WR;
        S_ACC_WR: state_q <= S_IDLE;

        S_RD_RD: state_q <= S_RD_CHK;

        S_RD_CHK: begin
          res_q.bin_count <= rd_cnt;
          neg_q           <= rd_sum[gbda_pkg::SUM_W-1];
          if (rd_cnt == '0) begin
            res_q.average   <= '0;
            res_q.bin_empty <= 1'b1;
            state_q         <= S_OUT;
          end else begin
            res_q.bin_empty <= 1'b0;
            state_q         <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            res_q.average <= neg_q ? -$signed(div_quot) : $signed(div_quot);
            state_q       <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_data_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/core/gbda_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Uses gbda_pkg for default widths.

module gbda_div #(
  parameter int DIVIDEND_W = gbda_pkg::AVG_W,
  parameter int DIVISOR_W  = gbda_pkg::CNT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int StepW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [StepW-1:0]      step_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvsr_q;
  logic [DIVIDEND_W-1:0] quot_q;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W+1:0] diff;
  logic                 fits;

  // Shift in next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quot_q[DIVIDEND_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvsr_q};
    fits  = ~diff[DIVISOR_W+1];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvsr_q <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quot_q <= {quot_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

@@ tb/tb_group_by_dims_average.sv @@
// Self-checking testbench for group_by_dims_average: directed and random transactions,
// with a bit-accurate predictor of bin sums, counts, coordinates and read averages.
// Depends on gbda_pkg and the group_by_dims_average RTL.

module tb_group_by_dims_average;
  timeunit 1ns;
  timeprecision 1ps;

  import gbda_pkg::*;

  // Code 3 is not decoded by the block: it must be dropped silently
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int NUM_BINS      = BIN_DEPTH_DEF;
  localparam int DIM_SLOTS     = MAX_DIMS_DEF;
  localparam int EXTENT_CAP    = 1 << EXTENT_BITS_DEF;
  // clearing pass after a restart plus the slowest item (a read)
  localparam int SETTLE_CYCLES = BIN_DEPTH_DEF + 100;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int PHASES        = 8;
  localparam int HOLD_CYCLES   = 600;
  localparam longint WATCHDOG_NS = 64'd10_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Register and aggregation state of the predictor
  logic [NUM_DIMS_W-1:0] reg_num_dims;
  logic [EXT_REG_W-1:0]  reg_extent [NUM_EXT_REGS];
  logic [MASK_W-1:0]     reg_mask;
  logic [SUM_W-1:0]      sum_store   [NUM_BINS];
  logic [CNT_W-1:0]      count_store [NUM_BINS];
  int unsigned           coord       [DIM_SLOTS];
  int unsigned           hot_bins [$];     // recently filled bins, read targets
  out_item_t             average_q [$];    // read results still to come

  int unsigned error_count   = 0;
  int unsigned hold_request  = 0;
  bit          tx_quiet      = 1'b0;
  bit          rx_quiet      = 1'b0;

  always #5 clk = ~clk;

  group_by_dims_average dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned dims_in_use();
    int unsigned n;
    n = reg_num_dims;
    if (n < 1) n = 1;
    if (n > DIM_SLOTS) n = DIM_SLOTS;
    return n;
  endfunction

  function automatic int unsigned extent_in_use(int unsigned d);
    int unsigned e;
    e = (d < NUM_EXT_REGS) ? reg_extent[d] : 1;
    if (e == 0) e = 1;
    if (e > EXTENT_CAP) e = EXTENT_CAP;
    return e;
  endfunction

  // Row-major index over the key dimensions, highest key fastest, wrapped to the store
  function automatic int unsigned bin_of_cell();
    longint unsigned idx;
    longint unsigned stride;
    idx = 0;
    stride = 1;
    for (int d = int'(dims_in_use()) - 1; d >= 0; d--) begin
      if (d < MASK_W && reg_mask[d]) begin
        idx += coord[d] * stride;
        stride *= extent_in_use(d);
      end
    end
    return int'(idx % NUM_BINS);
  endfunction

  // Mixed-radix increment; a coordinate at or past its extent carries
  function automatic void step_coords();
    for (int d = int'(dims_in_use()) - 1; d >= 0; d--) begin
      if (coord[d] + 1 >= extent_in_use(d)) begin
        coord[d] = 0;
      end else begin
        coord[d] = coord[d] + 1;
        return;
      end
    end
  endfunction

  function automatic void clear_bins();
    foreach (sum_store[i]) begin
      sum_store[i]   = '0;
      count_store[i] = '0;
    end
    foreach (coord[d]) coord[d] = 0;
    hot_bins.delete();
  endfunction

  // Update the state for one accepted transaction; a read queues its result
  function automatic void apply_item(in_item_t it);
    int unsigned      b;
    logic [SUM_W-1:0] neg_sum;
    logic [63:0]      mag;
    logic [63:0]      quot;
    out_item_t        res;
    case (it.func)
      FUNC_ACCUM: begin
        b = bin_of_cell();
        if (count_store[b] == 0) begin
          hot_bins.push_back(b);
          if (hot_bins.size() > 64) void'(hot_bins.pop_front());
        end
        sum_store[b] = sum_store[b] + it.cell_value;
        if (count_store[b] != '1) count_store[b] = count_store[b] + 1;
        step_coords();
      end
      FUNC_READ: begin
        b = it.bin_index;
        res = '0;
        res.bin_count = count_store[b];
        res.bin_empty = (count_store[b] == 0);
        if (count_store[b] != 0) begin
          // magnitude first, so the quotient truncates toward zero
          neg_sum = -sum_store[b];
          mag = sum_store[b][SUM_W-1] ? {32'b0, neg_sum} : {32'b0, sum_store[b]};
          quot = (mag << FRAC_BITS) / count_store[b];
          if (sum_store[b][SUM_W-1]) quot = -quot;
          res.average = quot[AVG_W-1:0];
        end
        average_q.push_back(res);
      end
      FUNC_RESTART: clear_bins();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v,
                                         logic [BIN_IDX_W-1:0] b);
    in_item_t it;
    it.func       = f;
    it.cell_value = v;
    it.bin_index  = b;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r < 2)       it.func = FUNC_RESTART;
    else if (r < 10) it.func = FUNC_UNUSED;
    else if (r < 60) it.func = FUNC_READ;
    else             it.func = FUNC_ACCUM;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: it.cell_value = 32'sh7fffffff;
          1: it.cell_value = 32'sh80000000;
          2: it.cell_value = '0;
          default: it.cell_value = -1;
        endcase
      end
      1, 2, 3, 4: it.cell_value = int'($urandom_range(0, 200)) - 100;
      default: it.cell_value = $urandom;
    endcase
    if (hot_bins.size() != 0 && $urandom_range(0, 3) != 0)
      it.bin_index = BIN_IDX_W'(hot_bins[$urandom_range(0, hot_bins.size() - 1)]);
    else
      it.bin_index = BIN_IDX_W'($urandom);
    return it;
  endfunction

  function automatic int unsigned rand_extent();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, 2047);
    return $urandom_range(0, 6);
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    apply_item(it);
  endtask

  // Drop valid, wait for every read result, then let a restart or accumulate finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (average_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NUM_DIMS:    reg_num_dims  = val[NUM_DIMS_W-1:0];
      CFG_EXTENT_DIM0: reg_extent[0] = val;
      CFG_EXTENT_DIM1: reg_extent[1] = val;
      CFG_EXTENT_DIM2: reg_extent[2] = val;
      CFG_EXTENT_DIM3: reg_extent[3] = val;
      CFG_SELECT_MASK: reg_mask      = val[MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Full register set, written only once the block is idle
  task automatic configure(int unsigned dims, int unsigned e0, int unsigned e1,
                           int unsigned e2, int unsigned e3, int unsigned mask);
    settle();
    write_register(CFG_NUM_DIMS, CFG_DATA_W'(dims));
    write_register(CFG_EXTENT_DIM0, CFG_DATA_W'(e0));
    write_register(CFG_EXTENT_DIM1, CFG_DATA_W'(e1));
    write_register(CFG_EXTENT_DIM2, CFG_DATA_W'(e2));
    write_register(CFG_EXTENT_DIM3, CFG_DATA_W'(e3));
    write_register(CFG_SELECT_MASK, CFG_DATA_W'(mask));
  endtask

  // ---------------------------------------------------------------- tests

  // Reset registers: one cell per tile, every cell lands in bin 0
  task automatic test_reset_state();
    send_item(make_item(FUNC_READ, 0, 0));                  // empty bin
    send_item(make_item(FUNC_ACCUM, 32'sh80000000, 10'h3ff));
    send_item(make_item(FUNC_READ, 0, 0));                  // most negative sum
    send_item(make_item(FUNC_ACCUM, 32'sh7fffffff, 10'h3ff));
    send_item(make_item(FUNC_READ, 0, 0));                  // -1 / 2
    send_item(make_item(FUNC_UNUSED, -1, 10'h3ff));         // dropped
    send_item(make_item(FUNC_READ, 0, 10'h3ff));            // top bin, empty
  endtask

  // Truncation toward zero for both signs, wrapping sums, restart
  task automatic test_signed_averages();
    logic signed [VALUE_W-1:0] cells [6];
    cells = '{-7, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 3};
    configure(2, 2, 3, 1, 1, 4'b0001);   // key is the outer dimension only
    foreach (cells[i]) send_item(make_item(FUNC_ACCUM, cells[i], '0));
    send_item(make_item(FUNC_READ, 0, 0));
    send_item(make_item(FUNC_READ, 0, 1));
    send_item(make_item(FUNC_READ, 0, 2));
    send_item(make_item(FUNC_RESTART, 0, 0));
    send_item(make_item(FUNC_READ, 0, 1));
  endtask

  // Shrinking an extent under a running coordinate forces an early carry
  task automatic test_stale_coordinates();
    configure(1, 1024, 1, 1, 1, 4'b0001);
    send_item(make_item(FUNC_RESTART, 0, 0));
    repeat (3) send_item(make_item(FUNC_ACCUM, $urandom, '0));
    configure(1, 2, 1, 1, 1, 4'b0001);
    repeat (2) send_item(make_item(FUNC_ACCUM, $urandom, '0));
    send_item(make_item(FUNC_READ, 0, 3));
    send_item(make_item(FUNC_READ, 0, 0));
  endtask

  // Random transactions over register settings, extremes first
  task automatic test_random_phases();
    in_item_t    it;
    int unsigned counted;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(0, 0, 0, 0, 0, 4'b0000);
        1: configure(1, 1024, 1, 1, 1, 4'b0001);
        // outer coordinate left over from the last phase pushes the index past the store
        2: configure(2, 2047, 2047, 0, 0, 4'b0011);
        3: configure(7, 2047, 2047, 2047, 2047, 4'b1111);
        default: configure($urandom_range(0, 7), rand_extent(), rand_extent(),
                           rand_extent(), rand_extent(), $urandom_range(0, 15));
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        it = random_item();
        send_item(it);
        if (it.func != FUNC_UNUSED) counted++;
      end
    end
  endtask

  // Long receiver hold while reads keep coming, so the input side backs up
  task automatic test_output_backpressure();
    in_item_t it;
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      it = random_item();
      it.func = (i % 3 == 2) ? FUNC_ACCUM : FUNC_READ;
      send_item(it);
    end
    tx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // Output stall: random gaps, plus a long hold on request
  initial begin : receiver
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        out_stall <= 1'b1;
      end else begin
        if (!rx_quiet && $urandom_range(0, 3) == 0) gap_left = pick_gap(1'b0);
        out_stall <= (gap_left != 0);
      end
    end
  end

  // Each accepted result against the oldest pending read
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (average_q.size() == 0) begin
        $display("%0t: result with no read pending: average %0d empty %0b count %0d",
                 $time, out_data.average, out_data.bin_empty, out_data.bin_count);
        error_count++;
      end else begin
        want = average_q.pop_front();
        if (out_data.average !== want.average) begin
          $display("%0t: average mismatch: expected %0d, actual %0d",
                   $time, want.average, out_data.average);
          error_count++;
        end
        if (out_data.bin_empty !== want.bin_empty) begin
          $display("%0t: bin_empty mismatch: expected %0b, actual %0b",
                   $time, want.bin_empty, out_data.bin_empty);
          error_count++;
        end
        if (out_data.bin_count !== want.bin_count) begin
          $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                   $time, want.bin_count, out_data.bin_count);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    reg_num_dims = 3'd1;
    foreach (reg_extent[d]) reg_extent[d] = 11'd1;
    reg_mask = '0;
    clear_bins();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_signed_averages();
    test_stale_coordinates();
    test_random_phases();
    test_output_backpressure();

    settle();
    if (error_count == 0) begin
      $display("group_by_dims_average test passed");
    end else begin
      $display("group_by_dims_average test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(WATCHDOG_NS);
    $display("group_by_dims_average test failed");
    $finish;
  end

endmodule
